@@ hw/rtl/lpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Types and constants shared by the permutation generator and its cells.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int ELEM_W = 4;
   localparam int SIZE_W = 4;
   localparam int WORD_SLOTS = 8;
   localparam int WORD_W = ELEM_W * WORD_SLOTS;

   typedef logic [ELEM_W-1:0] elem_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_MARK,
      CELL_SWAP,
      CELL_SORT
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_SWAP,
      ST_SORT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cell_op_type op;
      logic        odd_phase;
      elem_type    pivot_val;
      elem_type    succ_val;
   } cell_ctrl_type;

   typedef struct packed {
      logic     any_asc;
      logic     gt;
      logic     sfx;
      elem_type pivot_val;
      elem_type succ_val;
   } cell_stat_type;

endpackage

@@ hw/rtl/lpg_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_cell
// One slot of the permutation. Compares with its neighbours to locate the
// pivot and successor, and takes part in odd-even exchange of the suffix.
// ----------------------------------------------------------------------------
module lpg_cell
   import lpg_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int NW      = 4,
   parameter int RESET_N = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [NW-1:0] n,
   input  elem_type      left_val,
   input  logic          left_sfx,
   input  elem_type      right_val,
   input  logic          right_sfx,
   input  logic          right_gt,
   input  logic          any_asc_in,
   output elem_type      val,
   output cell_stat_type stat
);

   localparam logic ParityBit = logic'(INDEX % 2);
   localparam elem_type ResetVal = (INDEX < RESET_N) ? ELEM_W'(INDEX + 1) : '0;

   elem_type val_ff, val_in;
   logic     sfx_ff, sfx_in;
   logic     piv_ff, piv_in;

   logic active, right_active, asc, any_out, is_pivot, gt, succ, left_role;

   always_comb begin
      active       = NW'(INDEX) < n;
      right_active = NW'(INDEX + 1) < n;
      asc          = right_active & (val_ff < right_val);
      any_out      = asc | any_asc_in;
      is_pivot     = asc & ~any_asc_in;
      gt           = sfx_ff & (val_ff > ctrl.pivot_val);
      succ         = gt & ~right_gt;
      left_role    = (ctrl.odd_phase == ParityBit);
   end

   always_comb begin
      val_in = val_ff;
      sfx_in = sfx_ff;
      piv_in = piv_ff;
      case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_LOAD: begin
            val_in = active ? ELEM_W'(INDEX + 1) : '0;
            sfx_in = 1'b0;
            piv_in = 1'b0;
         end
         CELL_MARK: begin
            sfx_in = active & ~any_out;
            piv_in = is_pivot;
         end
         CELL_SWAP: begin
            if (piv_ff) begin
               val_in = ctrl.succ_val;
            end else if (succ) begin
               val_in = ctrl.pivot_val;
            end
         end
         CELL_SORT: begin
            if (left_role) begin
               if (sfx_ff && right_sfx && (val_ff > right_val)) begin
                  val_in = right_val;
               end
            end else begin
               if (sfx_ff && left_sfx && (left_val > val_ff)) begin
                  val_in = left_val;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= ResetVal;
         sfx_ff <= 1'b0;
         piv_ff <= 1'b0;
      end else begin
         val_ff <= val_in;
         sfx_ff <= sfx_in;
         piv_ff <= piv_in;
      end
   end

   assign val            = val_ff;
   assign stat.any_asc   = any_out;
   assign stat.gt        = gt;
   assign stat.sfx       = sfx_ff;
   assign stat.pivot_val = is_pivot ? val_ff : '0;
   assign stat.succ_val  = succ ? val_ff : '0;

endmodule

@@ hw/rtl/lexicographic_permutation_generator.sv @@
// Sequence: restart, first request and exhausted words go from idle straight to
// finish, where the response is registered; a next word steps through mark, swap,
// MAX_N odd-even exchange passes over the cell row, then finish.
// Flow: one word in flight; finish waits until the response register is free.
// Reset: synchronous; set size 4, identity loaded, no response pending.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexicographic_permutation_generator
// Steps through the permutations of 1..n in lexicographic order using a row
// of cells, one per element, driven by a small sequencer.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator
   import lpg_pkg::*;
#(
   parameter int MAX_N = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_perm_word,
   output logic              rsp_is_last,
   output logic              rsp_exhausted,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_set_size
);

   localparam int NW     = $clog2(MAX_N + 1);
   localparam int PW     = $clog2(MAX_N);
   localparam int ResetN = (MAX_N < 4) ? MAX_N : 4;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              started_ff, started_in;
   logic              done_ff, done_in;
   logic              exh_ff, exh_in;
   logic [PW-1:0]     pass_ff, pass_in;
   elem_type          pv_ff, pv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_exh_ff, rsp_exh_in;

   logic              req_fire, csr_fire, load_req, out_free, finish_fire;
   logic [NW-1:0]     n_cur, n_new, n_cells;
   cell_ctrl_type     ctrl;
   elem_type          pivot_or, succ_or;
   logic [WORD_W-1:0] packed_word;

   elem_type          cell_val  [MAX_N];
   cell_stat_type     cell_stat [MAX_N];

   assign req_fire    = req_valid & req_ready;
   assign csr_fire    = csr_valid & csr_ready;
   assign load_req    = req_restart | ~started_ff;
   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign finish_fire = (state_ff == ST_FINISH) & out_free;

   // clamp set size to 1..MAX_N
   assign n_cur = (size_ff == '0) ? NW'(1) :
                  (size_ff > SIZE_W'(MAX_N)) ? NW'(MAX_N) : NW'(size_ff);
   assign n_new = (csr_set_size == '0) ? NW'(1) :
                  (csr_set_size > SIZE_W'(MAX_N)) ? NW'(MAX_N) : NW'(csr_set_size);
   assign n_cells = csr_fire ? n_new : n_cur;

   always_comb begin
      pivot_or = '0;
      succ_or  = '0;
      for (int k = 0; k < MAX_N; k++) begin
         pivot_or = pivot_or | cell_stat[k].pivot_val;
         succ_or  = succ_or | cell_stat[k].succ_val;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (load_req || done_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK:  state_in = ST_SWAP;
         ST_SWAP:  state_in = ST_SORT;
         ST_SORT: begin
            if (pass_ff == PW'(MAX_N - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready      = 1'b0;
      csr_ready      = 1'b0;
      ctrl.op        = CELL_HOLD;
      ctrl.odd_phase = pass_ff[0];
      ctrl.pivot_val = pv_ff;
      ctrl.succ_val  = succ_or;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
            if (csr_fire || (req_fire && load_req)) begin
               ctrl.op = CELL_LOAD;
            end
         end
         ST_MARK:   ctrl.op = CELL_MARK;
         ST_SWAP:   ctrl.op = CELL_SWAP;
         ST_SORT:   ctrl.op = CELL_SORT;
         ST_FINISH: ctrl.op = CELL_HOLD;
         default:   ctrl.op = CELL_HOLD;
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < WORD_SLOTS; g++) begin : g_pack
         if (g < MAX_N) begin : g_used
            assign packed_word[g*ELEM_W +: ELEM_W] = cell_val[g];
         end else begin : g_zero
            assign packed_word[g*ELEM_W +: ELEM_W] = '0;
         end
      end

      for (g = 0; g < MAX_N; g++) begin : g_cell
         elem_type l_val, r_val;
         logic     l_sfx, r_sfx, r_gt, r_any;
         if (g == 0) begin : g_left_edge
            assign l_val = '0;
            assign l_sfx = 1'b0;
         end else begin : g_left
            assign l_val = cell_val[g-1];
            assign l_sfx = cell_stat[g-1].sfx;
         end
         if (g == MAX_N - 1) begin : g_right_edge
            assign r_val = '0;
            assign r_sfx = 1'b0;
            assign r_gt  = 1'b0;
            assign r_any = 1'b0;
         end else begin : g_right
            assign r_val = cell_val[g+1];
            assign r_sfx = cell_stat[g+1].sfx;
            assign r_gt  = cell_stat[g+1].gt;
            assign r_any = cell_stat[g+1].any_asc;
         end
         lpg_cell #(
            .INDEX   (g),
            .NW      (NW),
            .RESET_N (ResetN)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .n          (n_cells),
            .left_val   (l_val),
            .left_sfx   (l_sfx),
            .right_val  (r_val),
            .right_sfx  (r_sfx),
            .right_gt   (r_gt),
            .any_asc_in (r_any),
            .val        (cell_val[g]),
            .stat       (cell_stat[g])
         );
      end
   endgenerate

   always_comb begin
      size_in      = csr_fire ? csr_set_size : size_ff;
      exh_in       = exh_ff;
      pass_in      = pass_ff;
      pv_in        = pv_ff;
      started_in   = started_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_exh_in   = rsp_exh_ff;
      if (req_fire) begin
         exh_in = ~load_req & done_ff;
      end
      if (state_ff == ST_MARK) begin
         pv_in = pivot_or;
      end
      if (state_ff == ST_SORT) begin
         pass_in = pass_ff + PW'(1);
      end else begin
         pass_in = '0;
      end
      if (finish_fire) begin
         started_in   = 1'b1;
         done_in      = exh_ff | ~cell_stat[0].any_asc;
         rsp_valid_in = 1'b1;
         rsp_word_in  = exh_ff ? '0 : packed_word;
         rsp_last_in  = ~exh_ff & ~cell_stat[0].any_asc;
         rsp_exh_in   = exh_ff;
      end
      if (csr_fire) begin
         started_in = 1'b0;
         done_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_W'(4);
         started_ff   <= 1'b0;
         done_ff      <= 1'b0;
         exh_ff       <= 1'b0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         started_ff   <= started_in;
         done_ff      <= done_in;
         exh_ff       <= exh_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pv_ff       <= pv_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_exh_ff  <= rsp_exh_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_perm_word = rsp_word_ff;
   assign rsp_is_last   = rsp_last_ff;
   assign rsp_exhausted = rsp_exh_ff;

endmodule

@@ hw/rtl/lpg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks on the response channel of the permutation generator.
// ----------------------------------------------------------------------------
module lpg_checker
   import lpg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_perm_word,
   input logic              rsp_is_last,
   input logic              rsp_exhausted
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before acceptance");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_perm_word) && $stable(rsp_is_last) && $stable(rsp_exhausted))
      else $error("stalled response word changed");

   a_exh_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |-> (rsp_perm_word == '0) && !rsp_is_last)
      else $error("exhausted word carries a permutation");

   a_first_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_exhausted |-> (rsp_perm_word[ELEM_W-1:0] != '0))
      else $error("permutation word has an empty first slot");

endmodule

bind lexicographic_permutation_generator lpg_checker u_lpg_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_perm_word (rsp_perm_word),
   .rsp_is_last   (rsp_is_last),
   .rsp_exhausted (rsp_exhausted)
);

@@ verif/lexicographic_permutation_generator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexicographic_permutation_generator_test
// Drives restart and next words into the permutation generator and checks
// every returned permutation, last-permutation flag and exhaustion flag
// against an in-bench next-permutation model. The set size is rewritten
// between phases, over its full range, while the block is idle.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator_test;
   import lpg_pkg::*;

   localparam int MAX_N = 8;
   localparam int RANDOM_WORDS = 800;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD = 400;
   localparam bit REQ_NEXT = 1'b0;
   localparam bit REQ_RESTART = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              exhausted;
   } perm_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_restart = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_perm_word;
   logic              rsp_is_last;
   logic              rsp_exhausted;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_set_size = '0;

   // permutation model state
   elem_type          perm_state [MAX_N];
   logic [SIZE_W-1:0] size_reg;
   bit                done_state;
   bit                started_state;

   bit                request_queue [$];
   perm_result_type   expected_perms [$];
   perm_result_type   want;

   int                send_gap = 0;
   int                hold_left = 0;
   bit                calm_phase = 1'b0;
   bit                long_hold_pending = 1'b0;
   int                cycle_count = 0;
   int                errors = 0;
   int                words_checked = 0;
   int                last_seen = 0;
   int                exhausted_seen = 0;
   int                size_writes = 0;

   lexicographic_permutation_generator #(
      .MAX_N(MAX_N)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_perm_word(rsp_perm_word),
      .rsp_is_last  (rsp_is_last),
      .rsp_exhausted(rsp_exhausted),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_set_size (csr_set_size)
   );

   always #1 clock = ~clock;

   function automatic int active_size(logic [SIZE_W-1:0] value);
      int n;
      n = int'(value);
      if (n < 1) n = 1;
      if (n > MAX_N) n = MAX_N;
      return n;
   endfunction

   function automatic void load_identity();
      int n;
      int k;
      n = active_size(size_reg);
      for (k = 0; k < MAX_N; k++)
         perm_state[k] = (k < n) ? elem_type'(k + 1) : '0;
   endfunction

   function automatic void model_set_size(logic [SIZE_W-1:0] value);
      size_reg = value;
      load_identity();
      done_state = 1'b0;
      started_state = 1'b0;
   endfunction

   function automatic bit is_descending(int n);
      int k;
      for (k = 0; k + 1 < n; k++)
         if (perm_state[k] < perm_state[k + 1]) return 1'b0;
      return 1'b1;
   endfunction

   // pivot, swap with rightmost larger element, reverse suffix
   function automatic bit step_permutation(int n);
      int       i;
      int       j;
      int       lo;
      int       hi;
      elem_type t;
      if (n < 2) return 1'b0;
      i = n - 1;
      while (i > 0 && perm_state[i - 1] >= perm_state[i]) i--;
      if (i == 0) return 1'b0;
      i--;
      j = n - 1;
      while (j > i && perm_state[j] <= perm_state[i]) j--;
      t = perm_state[i];
      perm_state[i] = perm_state[j];
      perm_state[j] = t;
      lo = i + 1;
      hi = n - 1;
      while (lo < hi) begin
         t = perm_state[lo];
         perm_state[lo] = perm_state[hi];
         perm_state[hi] = t;
         lo++;
         hi--;
      end
      return 1'b1;
   endfunction

   function automatic perm_result_type predict_permutation(bit restart);
      perm_result_type r;
      int              n;
      int              k;
      r = '0;
      n = active_size(size_reg);
      if (restart || !started_state) begin
         load_identity();
         started_state = 1'b1;
      end else if (done_state) begin
         r.exhausted = 1'b1;
         return r;
      end else if (!step_permutation(n)) begin
         done_state = 1'b1;
         r.exhausted = 1'b1;
         return r;
      end
      done_state = is_descending(n);
      for (k = 0; k < n && k < WORD_SLOTS; k++)
         r.word[ELEM_W*k +: ELEM_W] = perm_state[k];
      r.last = done_state;
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (calm_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_request(bit restart);
      request_queue.insert(request_queue.size(), restart);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_perms.insert(expected_perms.size(), predict_permutation(req_restart));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_restart <= request_queue.pop_front();
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_perms.size() == 0) begin
               $error("unexpected response word: perm_word %h", rsp_perm_word);
               errors++;
            end else begin
               want = expected_perms.pop_front();
               if (rsp_perm_word !== want.word) begin
                  $error("perm_word: expected %h, got %h", want.word, rsp_perm_word);
                  errors++;
               end
               if (rsp_is_last !== want.last) begin
                  $error("is_last: expected %0d, got %0d", want.last, rsp_is_last);
                  errors++;
               end
               if (rsp_exhausted !== want.exhausted) begin
                  $error("exhausted: expected %0d, got %0d", want.exhausted, rsp_exhausted);
                  errors++;
               end
               if (want.last) last_seen++;
               if (want.exhausted) exhausted_seen++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            hold_left = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_valid || expected_perms.size() != 0);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] value);
      wait_drained();
      repeat (MAX_N + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_set_size <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      csr_set_size <= SIZE_W'($urandom_range(0, 15));
      model_set_size(value);
      size_writes++;
      @(negedge clock);
   endtask

   task automatic queue_words(input int count, input int restart_odds);
      int k;
      for (k = 0; k < count; k++)
         add_request(($urandom_range(1, restart_odds) == 1) ? REQ_RESTART : REQ_NEXT);
   endtask

   initial begin
      int               random_total;
      int               phase;
      int               n;
      int               span;
      int               count;
      int               r;
      int               k;
      logic [SIZE_W-1:0] size_pick;

      model_set_size(SIZE_W'(4));
      size_writes = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size of four, next before any restart
      calm_phase = 1'b1;
      add_request(REQ_NEXT);
      add_request(REQ_NEXT);
      add_request(REQ_NEXT);
      add_request(REQ_RESTART);
      add_request(REQ_NEXT);
      // single element: identity is final, then exhausted
      write_size(SIZE_W'(1));
      calm_phase = 1'b0;
      add_request(REQ_NEXT);
      add_request(REQ_NEXT);
      add_request(REQ_RESTART);
      add_request(REQ_NEXT);
      // zero size acts as one
      write_size(SIZE_W'(0));
      add_request(REQ_NEXT);
      add_request(REQ_NEXT);
      write_size(SIZE_W'(2));
      add_request(REQ_RESTART);
      add_request(REQ_NEXT);
      add_request(REQ_NEXT);
      add_request(REQ_NEXT);
      // oversize clamps to the full row
      write_size(SIZE_W'(15));
      add_request(REQ_RESTART);
      add_request(REQ_NEXT);
      add_request(REQ_NEXT);
      // full walk of three elements into exhaustion
      write_size(SIZE_W'(3));
      queue_words(7, 1000000);

      random_total = 0;
      phase = 0;
      while (random_total < RANDOM_WORDS) begin
         r = $urandom_range(0, 19);
         if (r == 0) size_pick = '0;
         else if (r == 1) size_pick = SIZE_W'($urandom_range(9, 15));
         else if (r < 4) size_pick = SIZE_W'($urandom_range(6, 8));
         else size_pick = SIZE_W'($urandom_range(1, 5));
         write_size(size_pick);
         calm_phase = ($urandom_range(0, 4) == 0);
         n = active_size(size_pick);
         span = 1;
         for (k = 2; k <= n; k++) span *= k;
         if (n <= 4) count = span + $urandom_range(0, 3);
         else count = $urandom_range(8, 40);
         // mostly clean walks, some noisy restart-heavy phases
         if ($urandom_range(0, 7) == 0) queue_words(count, 2);
         else queue_words(count, 40);
         if (phase == 2 || phase == 11) long_hold_pending = 1'b1;
         random_total += count;
         phase++;
      end

      wait_drained();
      repeat (MAX_N + 8) @(posedge clock);
      @(negedge clock);
      $display("Checked %0d words over %0d size writes and %0d random phases.",
               words_checked, size_writes, phase);
      $display("Final permutations seen: %0d, exhausted replies seen: %0d.",
               last_seen, exhausted_seen);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
